// ===== hw/rtl/bvs_pkg.sv =====
// ----------------------------------------------------------------------------
// bvs_pkg: shared types, constants and helpers for the bone skinning unit
// Table geometry, port packing, register indexes and Q16.16 rounding helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package bvs_pkg;

    localparam int MAX_BONES      = 128;
    localparam int WORDS_PER_BONE = 12;
    localparam int TABLE_DEPTH    = MAX_BONES * WORDS_PER_BONE;
    localparam int TABLE_AW       = $clog2(TABLE_DEPTH);
    localparam int BONE_W         = 7;
    localparam int WORD_W         = 4;

    localparam int S_TDATA_W = 216;
    localparam int M_TDATA_W = 192;
    localparam int S_TUSER_W = 2;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // request kinds carried on tuser
    localparam logic [1:0] REQ_LOAD_CUR  = 2'd0;
    localparam logic [1:0] REQ_LOAD_PREV = 2'd1;
    localparam logic [1:0] REQ_WEIGHT    = 2'd2;

    // configuration register indexes
    localparam logic CFG_BACK_LERP  = 1'b0;
    localparam logic CFG_NORMALS_EN = 1'b1;

    // round half up of a 65-bit product, Q32 -> Q16
    function automatic logic signed [48:0] rnd16_p(input logic signed [64:0] v);
        logic signed [64:0] t;
        t = v + 65'sd32768;
        return t[64:16];
    endfunction

    // round half up of the 66-bit weighted term
    function automatic logic signed [49:0] rnd16_w(input logic signed [65:0] v);
        logic signed [65:0] t;
        t = v + 66'sd32768;
        return t[65:16];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
        logic signed [47:0] r;
        if (v > 50'sh0_7FFF_FFFF_FFFF) begin
            r = 48'sh7FFF_FFFF_FFFF;
        end else if (v < -50'sh0_8000_0000_0000) begin
            r = 48'sh8000_0000_0000;
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [47:0] v);
        logic [31:0] r;
        if (v > 48'sh0000_7FFF_FFFF) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -48'sh0000_8000_0000) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bone_lerp_vertex_skinning_unit.sv =====
// ----------------------------------------------------------------------------
// bone_lerp_vertex_skinning_unit: linear blend skinning with frame lerp
// Q16.16 skinning of vertices against two bone tables on one shared multiplier.
// ----------------------------------------------------------------------------
// Usage
//   Slave stream (i_s_*): tuser selects the request: load a current-frame
//   word, load a previous-frame word, or a vertex weight. tlast marks the
//   last weight of a vertex. Loads complete in the accept cycle and the
//   unit stays ready. A weight transaction occupies the unit for the
//   matrix blend (12 words x read, multiply, add) and for a transform
//   pass (3 rows x 3 multiply/accumulate + translation + 4 weighting
//   steps) on the position and, with normals on, on the normal; a last
//   weight then hands the vertex to the output register. The 7-bit bone
//   index cannot name a bone beyond the table.
//   Every product goes through the single 33x32 multiplier.
//   Master stream (o_m_*): one transaction per vertex, on its last weight.
//   The output register holds a result while the receiver stalls; the unit
//   keeps taking items and only waits when the next vertex is done while
//   the previous one is still unaccepted.
//   Config channel: write back_lerp (index 0) or normals_enable (index 1)
//   while idle; always ready.
//   Reset (synchronous, active low) clears sums, config to back_lerp 0 and
//   normals on, and the output valid. Bone tables are undefined until
//   loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module bone_lerp_vertex_skinning_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // tdata: bone_index, word_index, word_value, bone_weight, offset_x,
    //        offset_y, offset_z, normal_x, normal_y, normal_z, zero pad
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [bvs_pkg::S_TDATA_W-1:0] i_s_tdata,
    // tuser: req_type
    input  wire logic [bvs_pkg::S_TUSER_W-1:0] i_s_tuser,
    input  wire logic                          i_s_tlast,
    // tdata: pos_x, pos_y, pos_z, norm_x, norm_y, norm_z
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic      [bvs_pkg::M_TDATA_W-1:0] o_m_tdata,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic                          i_cfg_index,
    input  wire logic [16:0]                   i_cfg_data
);

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_RD     = 13'b0000000000010,
        ST_BL_MUL = 13'b0000000000100,
        ST_BL_ADD = 13'b0000000001000,
        ST_T_MUL  = 13'b0000000010000,
        ST_T_ACC  = 13'b0000000100000,
        ST_T_FIN  = 13'b0000001000000,
        ST_W_HI   = 13'b0000010000000,
        ST_W_LO   = 13'b0000100000000,
        ST_W_ADD  = 13'b0001000000000,
        ST_W_ACC  = 13'b0010000000000,
        ST_EMIT   = 13'b0100000000000,
        ST_SKIP   = 13'b1000000000000
    } t_state;

    localparam int AW = bvs_pkg::TABLE_AW;

    // input field unpacking
    logic [6:0]         s_bone;
    logic [3:0]         s_word;
    logic [31:0]        s_value;
    logic [16:0]        s_weight;
    logic signed [31:0] s_off [3];
    logic signed [17:0] s_nrm [3];

    assign s_bone   = i_s_tdata[6:0];
    assign s_word   = i_s_tdata[10:7];
    assign s_value  = i_s_tdata[42:11];
    assign s_weight = i_s_tdata[59:43];
    assign s_off[0] = i_s_tdata[91:60];
    assign s_off[1] = i_s_tdata[123:92];
    assign s_off[2] = i_s_tdata[155:124];
    assign s_nrm[0] = i_s_tdata[173:156];
    assign s_nrm[1] = i_s_tdata[191:174];
    assign s_nrm[2] = i_s_tdata[209:192];

    t_state r_state, n_state;
    logic   s_acc;
    logic   bone_ok;
    logic   load_ok;

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign s_acc = i_s_tvalid && o_s_tready;
    assign bone_ok = (int'(s_bone) < bvs_pkg::MAX_BONES);
    assign load_ok = bone_ok && (int'(s_word) < bvs_pkg::WORDS_PER_BONE);

    // config registers
    logic [16:0] r_back_lerp;
    logic        r_norm_en;

    // latched weight item
    logic [AW-1:0]      r_base;
    logic [16:0]        r_weight;
    logic signed [31:0] r_off [3];
    logic signed [17:0] r_nrm [3];
    logic               r_last;

    // sequencer counters
    logic [3:0] r_word;
    logic [1:0] r_row;
    logic [1:0] r_col;
    logic       r_pass;   // 0 position, 1 normal

    // datapath
    logic signed [31:0] r_m [12];
    logic signed [64:0] r_prod;
    logic signed [49:0] r_t;
    logic signed [65:0] r_wsum;
    logic signed [47:0] r_pos_sum [3];
    logic signed [47:0] r_nrm_sum [3];

    logic                         r_out_valid;
    logic [bvs_pkg::M_TDATA_W-1:0] r_out_data;

    // tables
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic          we_cur, we_prev, re;
    logic [31:0]   cur_rd, prev_rd;

    assign waddr = AW'(s_bone) * AW'(bvs_pkg::WORDS_PER_BONE) + AW'(s_word);
    assign we_cur  = s_acc && load_ok && (i_s_tuser == bvs_pkg::REQ_LOAD_CUR);
    assign we_prev = s_acc && load_ok && (i_s_tuser == bvs_pkg::REQ_LOAD_PREV);
    assign raddr = r_base + AW'(r_word);
    assign re = (r_state == ST_RD);

    bvs_ram #(.WIDTH(32), .DEPTH(bvs_pkg::TABLE_DEPTH)) u_cur_ram (
        .i_clk   (i_clk),
        .i_we    (we_cur),
        .i_waddr (waddr),
        .i_wdata (s_value),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (cur_rd)
    );

    bvs_ram #(.WIDTH(32), .DEPTH(bvs_pkg::TABLE_DEPTH)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (we_prev),
        .i_waddr (waddr),
        .i_wdata (s_value),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (prev_rd)
    );

    // shared multiplier operand select
    logic signed [32:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [64:0] mul_p;
    logic signed [31:0] m_sel;
    logic signed [31:0] m_tr;
    logic signed [31:0] v_sel;

    assign m_sel = r_m[{r_row, r_col}];
    assign m_tr  = r_m[{r_row, 2'd3}];
    assign v_sel = r_pass ? 32'(r_nrm[r_col]) : r_off[r_col];

    always_comb begin
        case (r_state)
            ST_BL_MUL: begin
                mul_a = {prev_rd[31], prev_rd} - {cur_rd[31], cur_rd};
                mul_b = {15'd0, r_back_lerp};
            end
            ST_T_MUL: begin
                mul_a = {m_sel[31], m_sel};
                mul_b = v_sel;
            end
            ST_W_HI: begin
                // signed upper part of the term
                mul_a = 33'($signed(r_t[47:24]));
                mul_b = {15'd0, r_weight};
            end
            ST_W_LO: begin
                mul_a = {9'd0, r_t[23:0]};
                mul_b = {15'd0, r_weight};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 65'(mul_a) * 65'(mul_b);

    logic signed [47:0] sum_sel;
    logic signed [49:0] sum_nxt;
    logic signed [49:0] t_fin;
    logic signed [31:0] blend;
    logic signed [48:0] prod_rnd;

    assign prod_rnd = bvs_pkg::rnd16_p(r_prod);
    assign blend    = $signed(cur_rd) + prod_rnd[31:0];
    assign sum_sel  = r_pass ? r_nrm_sum[r_row] : r_pos_sum[r_row];
    assign sum_nxt  = 50'(sum_sel) + bvs_pkg::rnd16_w(r_wsum);
    assign t_fin    = r_t + (r_pass ? 50'sd0 : 50'(m_tr));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_acc && i_s_tuser == bvs_pkg::REQ_WEIGHT) begin
                    n_state = bone_ok ? ST_RD : ST_SKIP;
                end
            end
            ST_RD:     n_state = ST_BL_MUL;
            ST_BL_MUL: n_state = ST_BL_ADD;
            ST_BL_ADD: n_state = (r_word == 4'd11) ? ST_T_MUL : ST_RD;
            ST_T_MUL:  n_state = ST_T_ACC;
            ST_T_ACC:  n_state = (r_col == 2'd2) ? ST_T_FIN : ST_T_MUL;
            ST_T_FIN:  n_state = ST_W_HI;
            ST_W_HI:   n_state = ST_W_LO;
            ST_W_LO:   n_state = ST_W_ADD;
            ST_W_ADD:  n_state = ST_W_ACC;
            ST_W_ACC: begin
                if (r_row != 2'd2 || (!r_pass && r_norm_en)) begin
                    n_state = ST_T_MUL;
                end else begin
                    n_state = r_last ? ST_EMIT : ST_IDLE;
                end
            end
            ST_SKIP:   n_state = r_last ? ST_EMIT : ST_IDLE;
            ST_EMIT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    logic emit_go;
    assign emit_go = (r_state == ST_EMIT) && (!r_out_valid || i_m_tready);

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_back_lerp <= '0;
            r_norm_en   <= 1'b1;
            r_out_valid <= 1'b0;
            r_word      <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_pass      <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_pos_sum[i] <= '0;
                r_nrm_sum[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                if (i_cfg_index == bvs_pkg::CFG_BACK_LERP) begin
                    r_back_lerp <= (i_cfg_data > bvs_pkg::ONE_Q16) ? bvs_pkg::ONE_Q16
                                                                   : i_cfg_data;
                end else begin
                    r_norm_en <= i_cfg_data[0];
                end
            end
            // a new vertex may replace one taken in the same cycle
            if (emit_go) begin
                r_out_valid <= 1'b1;
            end else if (o_m_tvalid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    r_word <= '0;
                    r_row  <= '0;
                    r_col  <= '0;
                    r_pass <= 1'b0;
                end
                ST_BL_ADD: r_word <= r_word + 4'd1;
                ST_T_ACC:  r_col <= r_col + 2'd1;
                ST_W_ACC: begin
                    if (r_pass) begin
                        r_nrm_sum[r_row] <= bvs_pkg::sat48(sum_nxt);
                    end else begin
                        r_pos_sum[r_row] <= bvs_pkg::sat48(sum_nxt);
                    end
                    r_col <= '0;
                    if (r_row == 2'd2) begin
                        r_row  <= '0;
                        r_pass <= 1'b1;
                    end else begin
                        r_row <= r_row + 2'd1;
                    end
                end
                ST_EMIT: begin
                    if (emit_go) begin
                        for (int i = 0; i < 3; i++) begin
                            r_pos_sum[i] <= '0;
                            r_nrm_sum[i] <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_base   <= AW'(s_bone) * AW'(bvs_pkg::WORDS_PER_BONE);
            r_weight <= (s_weight > bvs_pkg::ONE_Q16) ? bvs_pkg::ONE_Q16 : s_weight;
            r_last   <= i_s_tlast;
            for (int i = 0; i < 3; i++) begin
                r_off[i] <= s_off[i];
                r_nrm[i] <= s_nrm[i];
            end
        end
        r_prod <= mul_p;
        case (r_state)
            ST_BL_ADD: r_m[r_word] <= blend;
            ST_T_ACC:  r_t <= r_t + 50'(prod_rnd);
            ST_T_FIN:  r_t <= 50'(bvs_pkg::sat48(t_fin));
            ST_W_LO:   r_wsum <= 66'(r_prod) <<< 24;
            ST_W_ADD:  r_wsum <= r_wsum + 66'(r_prod);
            default: ;
        endcase
        if (r_state == ST_BL_ADD || r_state == ST_W_ACC) begin
            r_t <= '0;
        end
        if (emit_go) begin
            r_out_data[31:0]    <= bvs_pkg::sat32(r_pos_sum[0]);
            r_out_data[63:32]   <= bvs_pkg::sat32(r_pos_sum[1]);
            r_out_data[95:64]   <= bvs_pkg::sat32(r_pos_sum[2]);
            r_out_data[127:96]  <= r_norm_en ? bvs_pkg::sat32(r_nrm_sum[0]) : 32'd0;
            r_out_data[159:128] <= r_norm_en ? bvs_pkg::sat32(r_nrm_sum[1]) : 32'd0;
            r_out_data[191:160] <= r_norm_en ? bvs_pkg::sat32(r_nrm_sum[2]) : 32'd0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

`default_nettype wire

// ===== hw/rtl/bvs_ram.sv =====
// ----------------------------------------------------------------------------
// bvs_ram: generic simple dual-port RAM
// One write port, one read port with registered, enable-held read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/bvs_chk.sv =====
// ----------------------------------------------------------------------------
// bvs_chk: port-level checker for the bone skinning unit
// Watches handshakes and the busy window of weight transactions.
// ----------------------------------------------------------------------------
`default_nettype none

module bvs_chk (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_s_tvalid,
    input wire logic                          o_s_tready,
    input wire logic [bvs_pkg::S_TUSER_W-1:0] i_s_tuser,
    input wire logic                          o_m_tvalid,
    input wire logic                          i_m_tready,
    input wire logic [bvs_pkg::M_TDATA_W-1:0] o_m_tdata
);

    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output valid dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("output data changed while stalled");

    a_weight_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser == bvs_pkg::REQ_WEIGHT |=> !o_s_tready)
        else $error("ready right after a weight transaction");

    a_emit_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(!o_s_tready))
        else $error("result appeared without a busy cycle");

endmodule

bind bone_lerp_vertex_skinning_unit bvs_chk u_bvs_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire

// ===== tb/bone_lerp_vertex_skinning_unit_test.sv =====
// ----------------------------------------------------------------------------
// bone_lerp_vertex_skinning_unit_test: self-checking bench for the skinning unit
// Fills a set of bones in both tables, then runs a directed table and random
// vertices under several back_lerp / normals settings and handshake patterns.
// Each emitted vertex is compared field by field with a Q16.16 predictor or a typed row.
// ----------------------------------------------------------------------------
`default_nettype none

module bone_lerp_vertex_skinning_unit_test;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;   // no operation, ignored by the unit
    localparam int         CYCLE_LIMIT = 1_000_000;
    localparam int         DRAIN_WAIT  = 250;    // longer than one weight transaction with normals on
    localparam int         N_LOADED    = 8;
    localparam int         PHASE_ITEMS = 80;
    localparam longint     S48_MAX     = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint     S48_MIN     = -S48_MAX - 1;

    typedef struct {
        logic [1:0]         req;
        logic [6:0]         bone;
        logic [3:0]         word;
        logic signed [31:0] wval;
        logic [16:0]        wt;
        logic signed [31:0] off [3];
        logic signed [17:0] nrm [3];
        logic               last;
    } t_req_item;

    typedef struct {
        logic signed [31:0] pos [3];
        logic signed [31:0] nrm [3];
    } t_vertex;

    typedef struct {
        t_req_item item;
        bit        typed;   // expected vertex given directly
        bit        emits;
        t_vertex   vtx;
    } t_dir_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [bvs_pkg::S_TDATA_W-1:0] i_s_tdata = '0;
    logic [bvs_pkg::S_TUSER_W-1:0] i_s_tuser = '0;
    logic                          i_s_tlast = 1'b0;
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    logic [bvs_pkg::M_TDATA_W-1:0] o_m_tdata;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic                          i_cfg_index = 1'b0;
    logic [16:0]                   i_cfg_data = '0;

    bone_lerp_vertex_skinning_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: shadow tables, sums and registers
    // ------------------------------------------------------------------
    longint  cur_tab  [bvs_pkg::TABLE_DEPTH];
    longint  prev_tab [bvs_pkg::TABLE_DEPTH];
    longint  pos_acc  [3];
    longint  nrm_acc  [3];
    longint  lerp_back;
    bit      norm_on;
    int      loaded_bones [N_LOADED];

    t_vertex vertex_q [$];     // vertices still owed by the unit
    int      fail_count;
    int      cycle_count;
    int      send_idle_pct;
    int      recv_idle_pct;

    function automatic longint rnd_q16(input longint v);
        return (v + 64'sd32768) >>> 16;    // arithmetic shift is a floor
    endfunction

    function automatic longint clamp48(input longint v);
        if (v > S48_MAX) return S48_MAX;
        if (v < S48_MIN) return S48_MIN;
        return v;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // rows of matrix times vector, weighted into the running sums
    task automatic blend_rows(inout longint acc [3], input longint mat [12],
                              input longint vec [3], input bit with_tr,
                              input longint w);
        longint t;
        for (int r = 0; r < 3; r++) begin
            t = rnd_q16(mat[r*4] * vec[0]) + rnd_q16(mat[r*4+1] * vec[1])
              + rnd_q16(mat[r*4+2] * vec[2]);
            if (with_tr) t += mat[r*4+3];
            t = clamp48(t);
            acc[r] = clamp48(acc[r] + rnd_q16(t * w));
        end
    endtask

    task automatic skin_predict(input t_req_item it, output bit emits, output t_vertex v);
        longint mat [12];
        longint ov [3];
        longint nv [3];
        longint w;
        int     base;
        emits = 1'b0;
        v = '{default: '{default: '0}};
        base = int'(it.bone) * bvs_pkg::WORDS_PER_BONE;
        if (it.req == bvs_pkg::REQ_LOAD_CUR || it.req == bvs_pkg::REQ_LOAD_PREV) begin
            if (it.word < bvs_pkg::WORDS_PER_BONE) begin
                if (it.req == bvs_pkg::REQ_LOAD_CUR) cur_tab[base + it.word] = it.wval;
                else prev_tab[base + it.word] = it.wval;
            end
            return;
        end
        if (it.req != bvs_pkg::REQ_WEIGHT) return;
        w = (it.wt > bvs_pkg::ONE_Q16) ? 64'sd65536 : longint'(it.wt);
        for (int i = 0; i < 12; i++) begin
            if (lerp_back == 0) mat[i] = cur_tab[base + i];
            else mat[i] = rnd_q16((65536 - lerp_back) * cur_tab[base + i]
                                  + lerp_back * prev_tab[base + i]);
        end
        for (int i = 0; i < 3; i++) begin
            ov[i] = it.off[i];
            nv[i] = it.nrm[i];
        end
        blend_rows(pos_acc, mat, ov, 1'b1, w);
        if (norm_on) blend_rows(nrm_acc, mat, nv, 1'b0, w);
        if (!it.last) return;
        emits = 1'b1;
        for (int i = 0; i < 3; i++) begin
            v.pos[i] = clamp32(pos_acc[i]);
            v.nrm[i] = norm_on ? clamp32(nrm_acc[i]) : 32'sd0;
            pos_acc[i] = 0;
            nrm_acc[i] = 0;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_req_item make_item(input logic [1:0] req, input int bone,
                                            input int word, input logic [31:0] wval,
                                            input logic [16:0] wt, input logic last);
        t_req_item it;
        it.req  = req;
        it.bone = bone[6:0];
        it.word = word[3:0];
        it.wval = wval;
        it.wt   = wt;
        it.last = last;
        for (int i = 0; i < 3; i++) begin
            it.off[i] = $urandom;
            it.nrm[i] = 18'($signed($urandom_range(131072)) - 65536);
        end
        return it;
    endfunction

    // send one transaction; prediction happens at acceptance
    task automatic send_req(input t_req_item it, input bit typed, input t_vertex tv);
        bit      emits;
        t_vertex pv;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= it.req;
        i_s_tlast  <= it.last;
        i_s_tdata  <= {6'd0, it.nrm[2], it.nrm[1], it.nrm[0], it.off[2], it.off[1],
                       it.off[0], it.wt, it.wval, it.word, it.bone};
        do @(posedge i_clk); while (!o_s_tready);
        skin_predict(it, emits, pv);
        if (emits) vertex_q.push_back(typed ? tv : pv);
    endtask

    task automatic write_reg(input logic idx, input logic [16:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == bvs_pkg::CFG_BACK_LERP)
            lerp_back = (val > bvs_pkg::ONE_Q16) ? 65536 : longint'(val);
        else norm_on = val[0];
        @(posedge i_clk);
    endtask

    // stop driving, let every owed vertex come out, then let the datapath settle
    task automatic drain_unit();
        i_s_tvalid <= 1'b0;
        while (vertex_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %08h expected %08h", what, got, want);
        fail_count++;
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall, compare each accepted vertex
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_vertex want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (vertex_q.size() == 0) begin
                report_mismatch("vertex with none owed", o_m_tdata[31:0], 32'd0);
            end else begin
                want = vertex_q.pop_front();
                for (int i = 0; i < 3; i++) begin
                    if (o_m_tdata[i*32 +: 32] !== want.pos[i])
                        report_mismatch($sformatf("pos[%0d]", i), o_m_tdata[i*32 +: 32],
                                        want.pos[i]);
                    if (o_m_tdata[96 + i*32 +: 32] !== want.nrm[i])
                        report_mismatch($sformatf("norm[%0d]", i),
                                        o_m_tdata[96 + i*32 +: 32], want.nrm[i]);
                end
            end
        end
        i_m_tready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // hard stop on a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("bone_lerp_vertex_skinning_unit verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_dir_row  dir_rows [$];
        t_dir_row  row;
        t_vertex   zero_v;
        t_vertex   dummy_v;
        t_req_item it;
        int        bone;
        int        nweights;
        int        sent;
        int        pick;
        logic [16:0] lerp_set  [6];
        bit          norm_set  [6];

        fail_count    = 0;
        cycle_count   = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        lerp_back     = 0;
        norm_on       = 1'b1;
        for (int i = 0; i < 3; i++) begin
            pos_acc[i] = 0;
            nrm_acc[i] = 0;
        end
        zero_v  = '{default: '{default: '0}};
        dummy_v = zero_v;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // bones 0..3 and 124..127 get every word in both tables
        for (int b = 0; b < N_LOADED; b++) begin
            loaded_bones[b] = (b < 4) ? b : 120 + b;
            for (int w = 0; w < bvs_pkg::WORDS_PER_BONE; w++) begin
                send_req(make_item(bvs_pkg::REQ_LOAD_CUR, loaded_bones[b], w, $urandom,
                                   17'd0, 1'b0), 1'b0, dummy_v);
                send_req(make_item(bvs_pkg::REQ_LOAD_PREV, loaded_bones[b], w, $urandom,
                                   17'd0, 1'b0), 1'b0, dummy_v);
            end
        end

        // directed table
        // zero weight on a fresh vertex leaves all sums at zero
        row = '{make_item(bvs_pkg::REQ_WEIGHT, 0, 0, 0, 17'd0, 1'b1), 1, 1, zero_v};
        dir_rows.push_back(row);
        // unused request kind: nothing
        row = '{make_item(REQ_UNUSED, 127, 15, 32'hFFFF_FFFF, 17'h1FFFF, 1'b1), 1, 0, zero_v};
        dir_rows.push_back(row);
        // loads with a word index past the matrix are dropped
        row = '{make_item(bvs_pkg::REQ_LOAD_CUR, 3, 12, 32'h7FFF_FFFF, 17'd0, 1'b0),
                1, 0, zero_v};
        dir_rows.push_back(row);
        row = '{make_item(bvs_pkg::REQ_LOAD_PREV, 3, 15, 32'h8000_0000, 17'd0, 1'b0),
                1, 0, zero_v};
        dir_rows.push_back(row);
        // extreme matrix words on bone 3
        for (int w = 0; w < 4; w++) begin
            row = '{make_item(bvs_pkg::REQ_LOAD_CUR, 3, w * 3,
                              (w % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF, 17'd0, 1'b0),
                    0, 0, zero_v};
            dir_rows.push_back(row);
        end
        row = '{make_item(bvs_pkg::REQ_LOAD_PREV, 127, 11, 32'h8000_0000, 17'd0, 1'b0),
                0, 0, zero_v};
        dir_rows.push_back(row);
        // full weight, extreme offsets and normals
        it = make_item(bvs_pkg::REQ_WEIGHT, 127, 0, 0, 17'd65536, 1'b1);
        it.off = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
        it.nrm = '{18'sd65536, 18'sd65536, 18'sd65536};
        row = '{it, 0, 1, zero_v};
        dir_rows.push_back(row);
        // out-of-range weight acts as one; sums saturate across weights
        it = make_item(bvs_pkg::REQ_WEIGHT, 3, 0, 0, 17'h1FFFF, 1'b0);
        it.off = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
        it.nrm = '{-18'sd65536, -18'sd65536, -18'sd65536};
        row = '{it, 0, 0, zero_v};
        dir_rows.push_back(row);
        row = '{make_item(bvs_pkg::REQ_WEIGHT, 3, 0, 0, 17'd65536, 1'b0), 0, 0, zero_v};
        dir_rows.push_back(row);
        row = '{make_item(bvs_pkg::REQ_WEIGHT, 3, 0, 0, 17'd65536, 1'b1), 0, 1, zero_v};
        dir_rows.push_back(row);
        // a plain three-weight vertex
        row = '{make_item(bvs_pkg::REQ_WEIGHT, 1, 0, 0, 17'd20000, 1'b0), 0, 0, zero_v};
        dir_rows.push_back(row);
        row = '{make_item(bvs_pkg::REQ_WEIGHT, 124, 0, 0, 17'd30000, 1'b0), 0, 0, zero_v};
        dir_rows.push_back(row);
        row = '{make_item(bvs_pkg::REQ_WEIGHT, 2, 0, 0, 17'd15536, 1'b1), 0, 1, zero_v};
        dir_rows.push_back(row);

        foreach (dir_rows[r])
            send_req(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].vtx);
        drain_unit();

        // register settings per phase, extremes included
        lerp_set = '{17'd65536, 17'd32768, 17'($urandom_range(1, 65535)), 17'h1FFFF,
                     17'd0, 17'($urandom_range(1, 65535))};
        norm_set = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(bvs_pkg::CFG_BACK_LERP, lerp_set[ph]);
            write_reg(bvs_pkg::CFG_NORMALS_EN, {16'd0, norm_set[ph]});
            case (ph / 2)
                0: begin send_idle_pct = 20; recv_idle_pct = 51; end
                1: begin send_idle_pct = 51; recv_idle_pct = 20; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    // well-formed vertex run of weights on loaded bones
                    nweights = $urandom_range(1, 4);
                    for (int k = 0; k < nweights; k++) begin
                        bone = loaded_bones[$urandom_range(N_LOADED - 1)];
                        it = make_item(bvs_pkg::REQ_WEIGHT, bone, $urandom_range(15),
                                       $urandom,
                                       ($urandom_range(9) == 0) ? 17'd65536
                                                                : 17'($urandom_range(65535)),
                                       k == nweights - 1);
                        send_req(it, 1'b0, dummy_v);
                        sent++;
                    end
                end else if (pick < 90) begin
                    // rewrite a word of a loaded bone
                    bone = loaded_bones[$urandom_range(N_LOADED - 1)];
                    send_req(make_item(2'($urandom_range(1)), bone, $urandom_range(11),
                                       $urandom, 17'($urandom), 1'($urandom_range(1))),
                             1'b0, dummy_v);
                    sent++;
                end else begin
                    // noise: unused kind or out-of-matrix load
                    it = make_item(($urandom_range(1) == 0) ? REQ_UNUSED
                                                            : 2'($urandom_range(1)),
                                   $urandom_range(127), $urandom_range(12, 15), $urandom,
                                   17'($urandom), 1'($urandom_range(1)));
                    send_req(it, 1'b0, dummy_v);
                    sent++;
                end
            end
            drain_unit();
        end

        if (fail_count == 0) begin
            $display("bone_lerp_vertex_skinning_unit verification clean");
        end else begin
            $display("bone_lerp_vertex_skinning_unit verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/bvs_pkg.sv
hw/rtl/bvs_ram.sv
hw/rtl/bone_lerp_vertex_skinning_unit.sv
hw/rtl/bvs_chk.sv
tb/bone_lerp_vertex_skinning_unit_test.sv
